// ----- hdl/hwl_pkg.sv -----
// Shared types, constants and the coefficient function of the Haar wavelet block.
package hwl_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int ROW_W         = 10;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int HALF_W        = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     RESET_SIZE       = 11'd512;

    // bias of 1024 keeps the difference positive; after >>3 it becomes +128
    localparam logic [10:0] DIFF_BIAS = 11'd1024;

    typedef enum logic [1:0] {
        BAND_LL = 2'd0,
        BAND_LH = 2'd1,
        BAND_HL = 2'd2,
        BAND_HH = 2'd3
    } band_t;

    typedef enum logic [2:0] {
        KIND_STORE = 3'b001,
        KIND_LEFT  = 3'b010,
        KIND_RIGHT = 3'b100
    } kind_t;

    typedef struct packed {
        logic [PIX_W-1:0]  a;
        logic [PIX_W-1:0]  b;
        logic [PIX_W-1:0]  c;
        logic [PIX_W-1:0]  d;
        logic [HALF_W-1:0] half_col;
        logic [HALF_W-1:0] half_row;
    } blk_t;

    function automatic logic [CH_W-1:0] haar_coef(input band_t bnd,
                                                 input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [CH_W-1:0] c,
                                                 input logic [CH_W-1:0] d);
        logic [9:0]      sum;
        logic [10:0]     dif;
        logic [CH_W-1:0] res;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        dif = '0;
        case (bnd)
            BAND_LL: res = sum[9:2];
            BAND_LH: begin
                dif = DIFF_BIAS + {3'b000, a} + {3'b000, b} - {3'b000, c} - {3'b000, d};
                res = dif[10:3];
            end
            BAND_HL: begin
                dif = DIFF_BIAS + {3'b000, a} + {3'b000, c} - {3'b000, b} - {3'b000, d};
                res = dif[10:3];
            end
            BAND_HH: begin
                dif = DIFF_BIAS + {3'b000, a} + {3'b000, d} - {3'b000, b} - {3'b000, c};
                res = dif[10:3];
            end
            default: res = sum[9:2];
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/haar_wavelet_2d_rgb_level_top.sv -----
// Top level of the one-level 2D Haar wavelet on an RGB raster stream.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   s        in         s_valid/s_ready      s_red_in, s_green_in, s_blue_in
//   m        out        m_valid/m_ready      m_band, m_half_col, m_half_row,
//                                            m_red/green/blue_out, m_block_done
//
// Even-row pixels are only stored; on odd rows each block yields four bands on the
// result port, so odd rows run slower than even rows, limited by the single result
// port. The right pixel reaches its first band through the line store read and then
// the block register. Reset is synchronous and needs no clearing pass; the line store
// is only read where the same frame wrote it.
// A stalled m channel backs up through one block register and then drops s_ready.
module haar_wavelet_2d_rgb_level_top
    import hwl_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CH_W-1:0]      s_red_in,
    input  logic [CH_W-1:0]      s_green_in,
    input  logic [CH_W-1:0]      s_blue_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_band,
    output logic [HALF_W-1:0]    m_half_col,
    output logic [HALF_W-1:0]    m_half_row,
    output logic [CH_W-1:0]      m_red_out,
    output logic [CH_W-1:0]      m_green_out,
    output logic [CH_W-1:0]      m_blue_out,
    output logic                 m_block_done
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    logic              blk_valid, blk_ready;
    blk_t              blk;

    assign cfg_ready = 1'b1;

    hwl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .blk_valid  (blk_valid),
        .blk_ready  (blk_ready),
        .blk        (blk)
    );

    hwl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    hwl_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .blk_valid    (blk_valid),
        .blk_ready    (blk_ready),
        .blk          (blk),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_band       (m_band),
        .m_half_col   (m_half_col),
        .m_half_row   (m_half_row),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_block_done (m_block_done)
    );

endmodule

// ----- hdl/hwl_ram.sv -----
// Generic simple dual-port RAM with registered read.
module hwl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/hwl_front.sv -----
// Pixel intake: config registers, raster counters, line store access, block assembly.
module hwl_front
    import hwl_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CH_W-1:0]      s_red_in,
    input  logic [CH_W-1:0]      s_green_in,
    input  logic [CH_W-1:0]      s_blue_in,
    output logic                 ram_we,
    output logic                 ram_re,
    output logic [ADDR_W-1:0]    ram_addr,
    output logic [PIX_W-1:0]     ram_wdata,
    input  logic [PIX_W-1:0]     ram_rdata,
    output logic                 blk_valid,
    input  logic                 blk_ready,
    output blk_t                 blk
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]  width_reg, height_reg;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic                s1_valid_reg;
    kind_t               s1_kind_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic [HALF_W-1:0]   s1_hc_reg, s1_hr_reg;
    logic [PIX_W-1:0]    a_reg, c_reg;

    logic [CMP_W-1:0]  w_ext;
    logic [CNT_W-1:0]  ew;
    logic [CFG_W-1:0]  eh;
    logic [CNT_W-1:0]  col_w, col_p;
    logic [CFG_W-1:0]  row_w, row_p;
    logic [ADDR_W-1:0] col_cur, hc_full;
    logic [ROW_W-1:0]  row_cur;
    kind_t             kind;
    logic              s1_adv, accept;
    logic [PIX_W-1:0]  px;

    // effective sizes: clamp, then round down to even
    always_comb begin
        w_ext = CMP_W'(width_reg);
        if (w_ext < CMP_W'(2)) begin
            ew = CNT_W'(2);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            ew = CNT_W'(MAX_WIDTH);
        end else begin
            ew = CNT_W'(w_ext);
        end
        ew[0] = 1'b0;
        if (height_reg < 11'd2) begin
            eh = 11'd2;
        end else if (height_reg > CFG_W'(MAX_HEIGHT)) begin
            eh = CFG_W'(MAX_HEIGHT);
        end else begin
            eh = height_reg;
        end
        eh[0] = 1'b0;
    end

    // wrap before use (covers a size change mid-frame), advance, wrap again
    always_comb begin
        col_w = CNT_W'(col_reg);
        row_w = {1'b0, row_reg};
        if (col_w >= ew) begin
            col_w = '0;
            row_w = row_w + 11'd1;
        end
        if (row_w >= eh) begin
            row_w = '0;
        end
        col_cur = col_w[ADDR_W-1:0];
        row_cur = row_w[ROW_W-1:0];

        col_p = CNT_W'(col_cur) + CNT_W'(1);
        row_p = {1'b0, row_cur};
        if (col_p >= ew) begin
            col_p = '0;
            row_p = row_p + 11'd1;
        end
        if (row_p >= eh) begin
            row_p = '0;
        end
        col_next = col_p[ADDR_W-1:0];
        row_next = row_p[ROW_W-1:0];

        if (!row_cur[0]) begin
            kind = KIND_STORE;
        end else if (!col_cur[0]) begin
            kind = KIND_LEFT;
        end else begin
            kind = KIND_RIGHT;
        end
        hc_full = col_cur >> 1;
    end

    assign px        = {s_blue_in, s_green_in, s_red_in};
    assign blk_valid = s1_valid_reg && (s1_kind_reg == KIND_RIGHT);
    assign s1_adv    = !blk_valid || blk_ready;
    assign s_ready   = s1_adv;
    assign accept    = s_valid && s_ready;

    // even rows only write, odd rows only read, so the two never meet in one cycle;
    // a read of the entry written last is at least one accept later
    assign ram_we    = accept && (kind == KIND_STORE);
    assign ram_re    = accept && (kind != KIND_STORE);
    assign ram_addr  = col_cur;
    assign ram_wdata = px;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_SIZE;
            height_reg <= RESET_SIZE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_STORE;
            c_reg        <= '0;
        end else begin
            if (accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
                s1_kind_reg  <= kind;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && (s1_kind_reg == KIND_LEFT)) begin
                c_reg <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg <= px;
            s1_hc_reg <= HALF_W'(hc_full);
            s1_hr_reg <= row_cur[ROW_W-1:1];
        end
        // top-left pixel arrives from the store while the left pixel is held in the s1 registers
        if (s1_valid_reg && (s1_kind_reg == KIND_LEFT)) begin
            a_reg <= ram_rdata;
        end
    end

    // read data holds while a block waits, since reads issue only on accept
    assign blk.a        = a_reg;
    assign blk.b        = ram_rdata;
    assign blk.c        = c_reg;
    assign blk.d        = s1_px_reg;
    assign blk.half_col = s1_hc_reg;
    assign blk.half_row = s1_hr_reg;

endmodule

// ----- hdl/hwl_emit.sv -----
// Result serializer: holds one 2x2 block and emits its four bands.
module hwl_emit
    import hwl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  blk_t              blk,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_band,
    output logic [HALF_W-1:0] m_half_col,
    output logic [HALF_W-1:0] m_half_row,
    output logic [CH_W-1:0]   m_red_out,
    output logic [CH_W-1:0]   m_green_out,
    output logic [CH_W-1:0]   m_blue_out,
    output logic              m_block_done
);

    logic  busy_reg;
    band_t band_reg;
    blk_t  blk_reg;
    logic  last;

    assign last      = busy_reg && (band_reg == BAND_HH) && m_ready;
    assign blk_ready = !busy_reg || last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            band_reg <= BAND_LL;
        end else if (blk_valid && blk_ready) begin
            busy_reg <= 1'b1;
            band_reg <= BAND_LL;
        end else if (busy_reg && m_ready) begin
            if (band_reg == BAND_HH) begin
                busy_reg <= 1'b0;
            end else begin
                band_reg <= band_t'(band_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (blk_valid && blk_ready) begin
            blk_reg <= blk;
        end
    end

    assign m_valid      = busy_reg;
    assign m_band       = band_reg;
    assign m_half_col   = blk_reg.half_col;
    assign m_half_row   = blk_reg.half_row;
    assign m_block_done = (band_reg == BAND_HH);
    assign m_red_out    = haar_coef(band_reg, blk_reg.a[7:0], blk_reg.b[7:0],
                                    blk_reg.c[7:0], blk_reg.d[7:0]);
    assign m_green_out  = haar_coef(band_reg, blk_reg.a[15:8], blk_reg.b[15:8],
                                    blk_reg.c[15:8], blk_reg.d[15:8]);
    assign m_blue_out   = haar_coef(band_reg, blk_reg.a[23:16], blk_reg.b[23:16],
                                    blk_reg.c[23:16], blk_reg.d[23:16]);

endmodule

// ----- hdl/hwl_checker.sv -----
// Port-level checker for the Haar wavelet top level, with its bind.
module hwl_checker
    import hwl_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_band,
    input logic [HALF_W-1:0] m_half_col,
    input logic [HALF_W-1:0] m_half_row,
    input logic [CH_W-1:0]   m_red_out,
    input logic              m_block_done
);

    // a stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_band) && $stable(m_half_col)
                                && $stable(m_red_out))
        else $error("stalled result changed");

    a_done_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_block_done == (m_band == BAND_HH)))
        else $error("block_done not on the diagonal band");

    // the bands of one block come in order, back to back, with the same coordinates
    a_band_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_block_done |=>
            m_valid && (m_band == $past(m_band) + 2'd1) && $stable(m_half_col)
            && $stable(m_half_row))
        else $error("band sequence broken inside a block");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind haar_wavelet_2d_rgb_level_top hwl_checker u_hwl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_band       (m_band),
    .m_half_col   (m_half_col),
    .m_half_row   (m_half_row),
    .m_red_out    (m_red_out),
    .m_block_done (m_block_done)
);
